/* hdl/usbhtr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB host transaction retry package
// Shared types, operation codes, result codes, configuration indexes and reset values for the retry core.
// ----------------------------------------------------------------------------
package usbhtr_pkg;

    // Largest NAK limit exponent that the hardware honors.
    localparam int NAK_MAX_POWER_DEF = 15;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NAK_POWER   = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd2;

    // Operation codes of an incoming request.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DONE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Host result codes with special handling.
    localparam logic [3:0] HR_NAK         = 4'd4;
    localparam logic [3:0] HR_BUS_TIMEOUT = 4'd14;

    // Result code reported when the whole transfer runs out of time.
    localparam logic [4:0] RC_XFER_TIMEOUT = 5'd16;

    // Reset values of the configuration registers.
    localparam logic [3:0]  NAK_POWER_RST   = 4'd15;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;
    localparam logic [15:0] TIMEOUT_MS_RST  = 16'd5000;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] token;
        logic [3:0] endpoint;
        logic [3:0] host_result;
    } req_in_t;

    typedef struct packed {
        logic       launch;
        logic [7:0] launch_code;
        logic       finished;
        logic [4:0] result_code;
    } req_out_t;

endpackage

/* hdl/usb_host_transaction_retry_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB host transaction retry core
// Dispatches one host transaction and relaunches it on NAK or bus timeout.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in channel (in_valid / in_stall / in_data). A start
// request launches token | endpoint, a completion request carries the host
// result of the last transfer, and a tick request marks one millisecond.
// Each request yields zero or one result on the out channel (out_valid /
// out_stall / out_data): either a launch of the held code, or the end of the
// transaction with its result code (16 for the overall transfer timeout).
// Completions and ticks while no transaction is running yield nothing.
// The core has an input register and a result register with the update
// logic between them. A request's result is loaded into the result register
// when the request leaves the input register. One request can be accepted
// every cycle while in_stall is low. When the receiver stalls, the waiting
// result holds and the input register still takes one more request;
// in_stall rises only when both are full. The user must write the
// configuration port (cfg_we, cfg_index, cfg_data) only while the core is
// idle; the core does not enforce it. Reset empties both registers, clears the
// transaction state and loads nak_power 15, retry_limit 3, timeout 5000 ms.
// ----------------------------------------------------------------------------
module usb_host_transaction_retry_core #(
    parameter int NAK_MAX_POWER = usbhtr_pkg::NAK_MAX_POWER_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  usbhtr_pkg::req_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output usbhtr_pkg::req_out_t out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // The NAK counter never needs to pass the largest limit it can reach.
    localparam int NakW = NAK_MAX_POWER;

    // Configuration registers.
    logic [3:0]  nak_power_reg;
    logic [7:0]  retry_limit_reg;
    logic [15:0] timeout_ms_reg;

    // Transaction state.
    logic            busy_reg,        busy_next;
    logic [15:0]     elapsed_ms_reg,  elapsed_ms_next;
    logic [NakW-1:0] nak_count_reg,   nak_count_next;
    logic [7:0]      retry_count_reg, retry_count_next;
    logic [7:0]      held_code_reg,   held_code_next;

    // Input register and result register.
    usbhtr_pkg::req_in_t  item_reg;
    logic                 item_valid_reg, item_valid_next;
    usbhtr_pkg::req_out_t out_reg;
    logic                 out_valid_reg,  out_valid_next;

    usbhtr_pkg::req_out_t res;
    logic                 res_valid;
    logic                 adv;
    logic                 in_take;

    logic [4:0]      nak_p;
    logic [NakW-1:0] nak_lim;
    logic [NakW-1:0] nak_inc;
    logic [7:0]      retry_inc;
    logic [15:0]     elapsed_inc;

    // ------------------------------------------------------------------
    // Configuration writes. An index beyond the register list is ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nak_power_reg   <= usbhtr_pkg::NAK_POWER_RST;
            retry_limit_reg <= usbhtr_pkg::RETRY_LIMIT_RST;
            timeout_ms_reg  <= usbhtr_pkg::TIMEOUT_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                usbhtr_pkg::CFG_NAK_POWER:   nak_power_reg   <= cfg_data[3:0];
                usbhtr_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[7:0];
                usbhtr_pkg::CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // NAK limit: 2^min(nak_power, NAK_MAX_POWER) - 1, built as a mask of
    // low ones. A limit of zero means NAKs are never counted out.
    // ------------------------------------------------------------------
    always_comb
    begin
        nak_p = {1'b0, nak_power_reg};
        if (nak_p > 5'(NAK_MAX_POWER))
        begin
            nak_p = 5'(NAK_MAX_POWER);
        end
        for (int i = 0; i < NakW; i++)
        begin
            nak_lim[i] = (5'(i) < nak_p);
        end
    end

    assign nak_inc     = nak_count_reg + NakW'(1);
    assign retry_inc   = retry_count_reg + 8'd1;
    // The elapsed count saturates at its largest value.
    assign elapsed_inc = (elapsed_ms_reg == 16'hffff) ? elapsed_ms_reg
                                                       : elapsed_ms_reg + 16'd1;

    // ------------------------------------------------------------------
    // Request decode and state update for the request in the input register.
    // ------------------------------------------------------------------
    always_comb
    begin
        busy_next        = busy_reg;
        elapsed_ms_next  = elapsed_ms_reg;
        nak_count_next   = nak_count_reg;
        retry_count_next = retry_count_reg;
        held_code_next   = held_code_reg;
        res_valid        = 1'b0;
        res              = '0;

        case (item_reg.operation)
            usbhtr_pkg::OP_START:
            begin
                // A start while busy simply restarts the transaction.
                busy_next        = 1'b1;
                held_code_next   = item_reg.token | {4'd0, item_reg.endpoint};
                elapsed_ms_next  = '0;
                nak_count_next   = '0;
                retry_count_next = '0;
                res_valid        = 1'b1;
                res.launch       = 1'b1;
                res.launch_code  = item_reg.token | {4'd0, item_reg.endpoint};
            end
            usbhtr_pkg::OP_DONE:
            begin
                if (busy_reg)
                begin
                    res_valid       = 1'b1;
                    res.launch      = 1'b1;
                    res.launch_code = held_code_reg;
                    if (item_reg.host_result == usbhtr_pkg::HR_NAK)
                    begin
                        nak_count_next = nak_inc;
                        if ((nak_lim != '0) && (nak_inc == nak_lim))
                        begin
                            busy_next = 1'b0;
                            res       = '0;
                        end
                    end
                    else if (item_reg.host_result == usbhtr_pkg::HR_BUS_TIMEOUT)
                    begin
                        // A retry limit of zero lets the counter wrap once.
                        retry_count_next = retry_inc;
                        if (retry_inc == retry_limit_reg)
                        begin
                            busy_next = 1'b0;
                            res       = '0;
                        end
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        res       = '0;
                    end
                    if (!busy_next)
                    begin
                        res.finished    = 1'b1;
                        res.result_code = {1'b0, item_reg.host_result};
                    end
                end
            end
            usbhtr_pkg::OP_TICK:
            begin
                if (busy_reg)
                begin
                    elapsed_ms_next = elapsed_inc;
                    if (elapsed_inc >= timeout_ms_reg)
                    begin
                        busy_next       = 1'b0;
                        res_valid       = 1'b1;
                        res.finished    = 1'b1;
                        res.result_code = usbhtr_pkg::RC_XFER_TIMEOUT;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. The input register moves on when its request makes no
    // result, or when the result register is empty or being emptied.
    // ------------------------------------------------------------------
    assign adv      = item_valid_reg && (!res_valid || !out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (adv)
        begin
            item_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            elapsed_ms_reg  <= '0;
            nak_count_reg   <= '0;
            retry_count_reg <= '0;
            held_code_reg   <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (adv)
            begin
                busy_reg        <= busy_next;
                elapsed_ms_reg  <= elapsed_ms_next;
                nak_count_reg   <= nak_count_next;
                retry_count_reg <= retry_count_next;
                held_code_reg   <= held_code_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        if (adv && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // A new transaction always begins with cleared counters.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> (elapsed_ms_reg == '0) && (nak_count_reg == '0)
                            && (retry_count_reg == '0))
        else $error("transaction began with stale counters");

    // A finishing result leaves the core idle.
    a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid && res.finished) |=> !busy_reg)
        else $error("core still busy after a finishing result");

    // While idle, only a start request can make a result.
    a_idle_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid && !busy_reg) |-> (item_reg.operation == usbhtr_pkg::OP_START))
        else $error("result made while idle by a request other than start");

    // Stalling the input means a request is waiting behind a full output.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");
`endif

endmodule
